// File: hw/rtl/sdspi_pkg.sv
// Shared types, codes and CRC helpers for the SD SPI command and block engine.
package sdspi_pkg;

  localparam int MAX_BLOCK_BYTES    = 512;
  localparam int MAX_RESPONSE_BYTES = 5;
  localparam int RES_SLOTS          = 6;

  localparam logic [9:0]  BLOCK_LEN_RST  = 10'd512;
  localparam logic [15:0] TIMEOUT_RST    = 16'd5000;

  // configuration register indexes
  localparam logic CFG_BLOCK_LENGTH = 1'b0;
  localparam logic CFG_TIMEOUT_MS   = 1'b1;

  // input opcodes
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_RX    = 2'd1;
  localparam logic [1:0] OP_BLOCK = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // final status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_TIMEOUT  = 4'd1;
  localparam logic [3:0] ST_ILLEGAL  = 4'd2;
  localparam logic [3:0] ST_CRC      = 4'd3;
  localparam logic [3:0] ST_ADDRESS  = 4'd4;
  localparam logic [3:0] ST_RANGE    = 4'd5;
  localparam logic [3:0] ST_UNKNOWN  = 4'd6;
  localparam logic [3:0] ST_CORRUPT  = 4'd7;
  localparam logic [3:0] ST_CC_ERR   = 4'd8;
  localparam logic [3:0] ST_ECC_FAIL = 4'd9;

  // protocol bytes
  localparam logic [7:0] CMD_PREFIX  = 8'h40;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [2:0]  resp_length;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [RES_SLOTS-1:0] item;
    logic [2:0]           n;
  } group_t;

  // x^k mod (x^7 + x^3 + 1); only ever called with constant k
  function automatic logic [6:0] crc7_xpow(input int unsigned k);
    logic [6:0] r;
    r = 7'h01;
    for (int unsigned j = 0; j < k; j++) begin
      r = r[6] ? ({r[5:0], 1'b0} ^ 7'h09) : {r[5:0], 1'b0};
    end
    return r;
  endfunction

  // CRC7 of a 40-bit command head, first bit sent in bit 39; linear sum of columns
  function automatic logic [6:0] crc7_msg(input logic [39:0] m);
    logic [6:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < 40; i++) begin
      if (m[i]) acc = acc ^ crc7_xpow(i + 7);
    end
    return acc;
  endfunction

  // CRC16-CCITT, one byte MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/sd_spi_command_and_block_engine_unit.sv
// Top level of the SD SPI host command and block engine.
// Takes one item per transfer on the input channel: a start command, a received MISO byte,
// a block-read start or a millisecond tick. An accepted item is held in the input register,
// then the core decodes it combinationally into a group of up to six results, which are
// loaded into the result group register and drain one per output transfer. Items that
// give at most one result flow at one per cycle while the output is not stalled; a start
// command gives six transmit bytes, so the next item enters the core in the cycle its last
// byte is taken. The first result is offered once the item has passed the input and result
// group registers. The user must write configuration (block_length, timeout_ms) through
// cfg_write only while the engine is idle; the block does not enforce this.
module sd_spi_command_and_block_engine_unit
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [5:0]  cmd_index,
  input  logic [31:0] cmd_argument,
  input  logic [2:0]  resp_length,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [3:0]  status,
  output logic        last
);

  logic [9:0]  block_length;
  logic [15:0] timeout_ms;
  logic        s1_valid;
  item_t       s1_item;
  logic        go;
  logic        free;
  group_t      group;
  res_t        head;

  assign go       = s1_valid && free;
  assign in_stall = s1_valid && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LEN_RST;
      timeout_ms   <= TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BLOCK_LENGTH: block_length <= cfg_data[9:0];
        CFG_TIMEOUT_MS:   timeout_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register: load on transfer, drop when consumed by the core
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{opcode, cmd_index, cmd_argument, resp_length, rx_byte};
    end
  end

  sdspi_core u_core (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .item         (s1_item),
    .block_length (block_length),
    .timeout_ms   (timeout_ms),
    .group        (group)
  );

  sdspi_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .load  (go),
    .group (group),
    .free  (free),
    .valid (out_valid),
    .stall (out_stall),
    .head  (head)
  );

  assign out_kind = head.kind;
  assign out_byte = head.data;
  assign status   = head.status;
  assign last     = head.last;

endmodule

// File: hw/rtl/sdspi_core.sv
// Engine state and per-item decode: framing, R1 and token decode, CRC16 check, timeout.
module sdspi_core
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  item_t       item,
  input  logic [9:0]  block_length,
  input  logic [15:0] timeout_ms,
  output group_t      group
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WAIT_R1    = 3'd1;
  localparam logic [2:0] PH_RESP       = 3'd2;
  localparam logic [2:0] PH_WAIT_TOKEN = 3'd3;
  localparam logic [2:0] PH_DATA       = 3'd4;
  localparam logic [2:0] PH_CRC        = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] crc16, crc16_next;
  logic [9:0]  byte_count, byte_count_next;
  logic [2:0]  expected_resp, expected_resp_next;
  logic [15:0] elapsed, elapsed_next;

  logic [15:0] elapsed_inc;
  logic [15:0] crc16_upd;
  logic [9:0]  bc_inc;
  logic [9:0]  eff_blen;
  logic [2:0]  rlen;
  logic [3:0]  r1_st;
  logic [3:0]  tok_st;
  logic [7:0]  head;
  logic [6:0]  crc7;
  logic [7:0]  rx;

  assign rx          = item.rx_byte;
  assign head        = CMD_PREFIX | {2'b00, item.cmd_index};
  assign crc7        = crc7_msg({head, item.cmd_argument});
  assign elapsed_inc = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
  assign crc16_upd   = crc16_byte(crc16, rx);
  assign bc_inc      = byte_count + 10'd1;

  always_comb begin
    if (block_length == 10'd0) eff_blen = 10'd1;
    else if (block_length > 10'(MAX_BLOCK_BYTES)) eff_blen = 10'(MAX_BLOCK_BYTES);
    else eff_blen = block_length;
    if (item.resp_length == 3'd0) rlen = 3'd1;
    else if (item.resp_length > 3'(MAX_RESPONSE_BYTES)) rlen = 3'(MAX_RESPONSE_BYTES);
    else rlen = item.resp_length;
  end

  // R1 error ranking and data error token decode
  always_comb begin
    if (rx[2]) r1_st = ST_ILLEGAL;
    else if (rx[3]) r1_st = ST_CRC;
    else if (rx[5]) r1_st = ST_ADDRESS;
    else if (rx[6]) r1_st = ST_RANGE;
    else if (rx[1] || rx[4]) r1_st = ST_UNKNOWN;
    else r1_st = ST_OK;
    if (rx[1]) tok_st = ST_CC_ERR;
    else if (rx[2]) tok_st = ST_ECC_FAIL;
    else if (rx[3]) tok_st = ST_RANGE;
    else tok_st = ST_UNKNOWN;
  end

  always_comb begin
    phase_next         = phase;
    crc16_next         = crc16;
    byte_count_next    = byte_count;
    expected_resp_next = expected_resp;
    elapsed_next       = elapsed;
    group              = '0;

    case (item.opcode)
      OP_CMD: begin
        group.item[0]      = '{KIND_TX, head, ST_OK, 1'b0};
        group.item[1]      = '{KIND_TX, item.cmd_argument[31:24], ST_OK, 1'b0};
        group.item[2]      = '{KIND_TX, item.cmd_argument[23:16], ST_OK, 1'b0};
        group.item[3]      = '{KIND_TX, item.cmd_argument[15:8], ST_OK, 1'b0};
        group.item[4]      = '{KIND_TX, item.cmd_argument[7:0], ST_OK, 1'b0};
        group.item[5]      = '{KIND_TX, {crc7, 1'b1}, ST_OK, 1'b0};
        group.n            = 3'd6;
        expected_resp_next = rlen;
        byte_count_next    = '0;
        elapsed_next       = '0;
        phase_next         = PH_WAIT_R1;
      end
      OP_BLOCK: begin
        phase_next      = PH_WAIT_TOKEN;
        elapsed_next    = '0;
        byte_count_next = '0;
        crc16_next      = '0;
      end
      OP_TICK: begin
        if (phase == PH_WAIT_R1 || phase == PH_WAIT_TOKEN) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= timeout_ms) begin
            group.item[0] = '{KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1};
            group.n       = 3'd1;
            phase_next    = PH_IDLE;
          end
        end
      end
      default: begin
        case (phase)
          PH_WAIT_R1: begin
            if (rx != BYTE_IDLE) begin
              group.item[0]   = '{KIND_RESP, rx, ST_OK, 1'b0};
              group.n         = 3'd1;
              byte_count_next = 10'd1;
              if (r1_st != ST_OK || expected_resp <= 3'd1) begin
                group.item[1] = '{KIND_STATUS, 8'h00, r1_st, 1'b1};
                group.n       = 3'd2;
                phase_next    = PH_IDLE;
              end else begin
                phase_next = PH_RESP;
              end
            end
          end
          PH_RESP: begin
            group.item[0]   = '{KIND_RESP, rx, ST_OK, 1'b0};
            group.n         = 3'd1;
            byte_count_next = bc_inc;
            if (bc_inc >= {7'd0, expected_resp}) begin
              group.item[1] = '{KIND_STATUS, 8'h00, ST_OK, 1'b1};
              group.n       = 3'd2;
              phase_next    = PH_IDLE;
            end
          end
          PH_WAIT_TOKEN: begin
            if (rx == TOKEN_START) begin
              phase_next      = PH_DATA;
              byte_count_next = '0;
              crc16_next      = '0;
            end else if (rx[7:4] == 4'h0 && rx[3:0] != 4'h0) begin
              group.item[0] = '{KIND_STATUS, 8'h00, tok_st, 1'b1};
              group.n       = 3'd1;
              phase_next    = PH_IDLE;
            end
          end
          PH_DATA: begin
            group.item[0]   = '{KIND_DATA, rx, ST_OK, 1'b0};
            group.n         = 3'd1;
            crc16_next      = crc16_upd;
            byte_count_next = bc_inc;
            if (bc_inc >= eff_blen) begin
              phase_next      = PH_CRC;
              byte_count_next = '0;
            end
          end
          PH_CRC: begin
            crc16_next      = crc16_upd;
            byte_count_next = bc_inc;
            if (bc_inc >= 10'd2) begin
              group.item[0]   = '{KIND_STATUS, 8'h00,
                                  (crc16_upd == 16'h0000) ? ST_OK : ST_CORRUPT, 1'b1};
              group.n         = 3'd1;
              phase_next      = PH_IDLE;
              byte_count_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      crc16         <= '0;
      byte_count    <= '0;
      expected_resp <= '0;
      elapsed       <= '0;
    end else if (go) begin
      phase         <= phase_next;
      crc16         <= crc16_next;
      byte_count    <= byte_count_next;
      expected_resp <= expected_resp_next;
      elapsed       <= elapsed_next;
    end
  end

endmodule

// File: hw/rtl/sdspi_outq.sv
// Result group register: holds the results of one item and drains them one per transfer.
module sdspi_outq
  import sdspi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  group_t     group,
  output logic       free,
  output logic       valid,
  input  logic       stall,
  output res_t       head
);

  res_t [RES_SLOTS-1:0] slot;
  logic [2:0]           cnt;
  logic [2:0]           idx;
  logic                 pop;

  assign valid = (idx != cnt);
  assign pop   = valid && !stall;
  // free when empty, or when the last result leaves this cycle
  assign free  = !valid || (pop && (idx + 3'd1 == cnt));

  always_comb begin
    head = '0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (idx == 3'(i)) head = slot[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot <= group.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= group.n;
      idx <= '0;
    end else if (pop) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

// File: hw/rtl/sdspi_checker.sv
// Port-level checker for the SD SPI engine and its bind to the top level.
module sdspi_checker
  import sdspi_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [3:0] status,
  input logic       last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // only a final status carries a status code or ends a transfer
  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_STATUS |-> status == ST_OK && !last)
    else $error("non-status result with status or last");

  a_status_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS |-> last && out_byte == 8'h00)
    else $error("status result malformed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS |-> status <= ST_ECC_FAIL)
    else $error("status code out of range");

endmodule

bind sd_spi_command_and_block_engine_unit sdspi_checker u_sdspi_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .status    (status),
  .last      (last)
);
